// ===== sv/tcsp_pkg.sv =====
// Package for the table cell slot placer.
// Holds the transfer item types, register codes, controller states and the
// command and status bundles shared by the controller and the datapath.
package tcsp_pkg;

    localparam int ROW_W      = 6;
    localparam int CELL_W     = 8;
    localparam int SPAN_W     = 16;
    localparam int CNT_W      = 7;
    localparam int BUDGET_W   = 13;
    localparam int AREA_W     = 14;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Largest value a seven-bit limit register can hold.
    localparam int LIMIT_MAX = 127;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_BUDGET    = 2'd2;

    localparam logic [CNT_W-1:0]    ROWS_RESET    = 7'd0;
    localparam logic [CNT_W-1:0]    COLUMNS_RESET = 7'd64;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET  = 13'd4096;

    typedef struct packed {
        logic              first_cell;
        logic [ROW_W-1:0]  row_number;
        logic [CELL_W-1:0] cell_number;
        logic [SPAN_W-1:0] raw_row_span;
        logic [SPAN_W-1:0] raw_column_span;
    } in_item_t;

    typedef struct packed {
        logic                placed;
        logic [ROW_W-1:0]    echo_row;
        logic [CELL_W-1:0]   echo_cell;
        logic [CNT_W-1:0]    row_end;
        logic [ROW_W-1:0]    column_start;
        logic [CNT_W-1:0]    column_end;
        logic [CNT_W-1:0]    grid_columns;
        logic [BUDGET_W-1:0] slots_used;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_OR_READ,
        S_OR_LAST,
        S_SCAN,
        S_AREA,
        S_CHECK,
        S_WR_READ,
        S_WR_LAST,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic rd_issue;
        logic acc;
        logic scan_step;
        logic area;
        logic commit;
        logic wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_table;
        logic last_issue;
        logic scan_fail;
        logic scan_found;
        logic budget_ok;
        logic out_free;
    } status_t;

endpackage

// ===== sv/tcsp_ctrl.sv =====
// Controller state machine of the table cell slot placer.
// Sequences one cell through setup, row gather, column scan, budget check and
// write-back. Depends on tcsp_pkg.
module tcsp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tcsp_pkg::status_t  status,
    output logic               in_stall,
    output tcsp_pkg::cmd_t     cmd
);
    import tcsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = status.in_table ? S_OR_READ : S_DONE;
            end
            S_OR_READ:
            begin
                if (status.last_issue)
                begin
                    state_next = S_OR_LAST;
                end
            end
            S_OR_LAST:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                priority if (status.scan_fail)
                begin
                    state_next = S_DONE;
                end
                else if (status.scan_found)
                begin
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.budget_ok ? S_WR_READ : S_DONE;
            end
            S_WR_READ:
            begin
                if (status.last_issue)
                begin
                    state_next = S_WR_LAST;
                end
            end
            S_WR_LAST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            S_OR_READ:
            begin
                cmd.rd_issue = 1'b1;
                cmd.acc      = 1'b1;
            end
            S_OR_LAST:
            begin
                cmd.acc = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_step = !status.scan_fail;
            end
            S_AREA:
            begin
                cmd.area = 1'b1;
            end
            S_CHECK:
            begin
                cmd.commit = status.budget_ok;
            end
            S_WR_READ:
            begin
                cmd.rd_issue = 1'b1;
                cmd.wr       = 1'b1;
            end
            S_WR_LAST:
            begin
                cmd.wr = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/tcsp_datapath.sv =====
// Datapath of the table cell slot placer: configuration registers, the
// occupancy memory with per-row valid bits, the column scanner, the counters
// and the output register. Depends on tcsp_pkg; driven by tcsp_ctrl.
module tcsp_datapath #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_enable,
    input  logic [tcsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcsp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  tcsp_pkg::in_item_t                   in_data,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output tcsp_pkg::out_item_t                  out_data,
    input  tcsp_pkg::cmd_t                       cmd,
    output tcsp_pkg::status_t                    status
);
    import tcsp_pkg::*;

    // Rows and columns past the largest limit register value are never reached.
    localparam int ROW_DEPTH = (MAX_ROWS < LIMIT_MAX) ? MAX_ROWS : LIMIT_MAX;
    localparam int COL_DEPTH = (MAX_COLUMNS < LIMIT_MAX) ? MAX_COLUMNS : LIMIT_MAX;
    localparam int RAW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int CAW = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;

    logic [CNT_W-1:0]    rows_cfg_reg;
    logic [CNT_W-1:0]    cols_cfg_reg;
    logic [BUDGET_W-1:0] budget_cfg_reg;

    in_item_t            item_reg;
    logic [CNT_W-1:0]    rs_reg;
    logic [CNT_W-1:0]    row_end_reg;
    logic [CNT_W-1:0]    ptr_reg;
    logic [COL_DEPTH-1:0] mask_reg;
    logic [CNT_W-1:0]    scan_col_reg;
    logic [CNT_W-1:0]    run_start_reg;
    logic [CNT_W-1:0]    run_len_reg;
    logic [CNT_W-1:0]    col_reg;
    logic [CNT_W-1:0]    cs_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [BUDGET_W-1:0] slot_count_reg;
    logic [CNT_W-1:0]    widest_reg;
    logic                placed_reg;

    logic [COL_DEPTH-1:0] mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] row_valid_reg;
    logic [COL_DEPTH-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [RAW-1:0]       rd_addr_reg;
    logic                 pend_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [CNT_W-1:0]    rc;
    logic [CNT_W-1:0]    mc;
    logic [CNT_W-1:0]    rows_left;
    logic [SPAN_W-1:0]   rspan_eff;
    logic [SPAN_W-1:0]   cspan_eff;
    logic [CNT_W-1:0]    rs_next;
    logic [RAW-1:0]      rd_addr;
    logic [COL_DEPTH-1:0] rd_data_eff;
    logic [COL_DEPTH-1:0] rect;
    logic                wr_en;
    logic                scan_bit;
    logic [CNT_W-1:0]    run_len_inc;
    logic                scan_fail;
    logic                scan_found;
    logic [CNT_W:0]      col_end_wide;
    logic [AREA_W:0]     slot_sum;

    assign rc = (rows_cfg_reg > CNT_W'(ROW_DEPTH)) ? CNT_W'(ROW_DEPTH) : rows_cfg_reg;
    assign mc = (cols_cfg_reg > CNT_W'(COL_DEPTH)) ? CNT_W'(COL_DEPTH) : cols_cfg_reg;
    assign rows_left = rc - {1'b0, item_reg.row_number};
    assign rspan_eff = (item_reg.raw_row_span == '0) ? SPAN_W'(1) : item_reg.raw_row_span;
    assign cspan_eff = (item_reg.raw_column_span == '0) ? SPAN_W'(1)
                                                        : item_reg.raw_column_span;
    assign rs_next = (rspan_eff < SPAN_W'(rows_left)) ? rspan_eff[CNT_W-1:0] : rows_left;

    assign rd_addr     = ptr_reg[RAW-1:0];
    assign rd_data_eff = rd_valid_reg ? rd_data_reg : '0;
    assign wr_en       = cmd.wr && pend_reg;

    assign scan_bit    = mask_reg[scan_col_reg[CAW-1:0]];
    assign run_len_inc = run_len_reg + 7'd1;
    assign scan_fail   = (scan_col_reg >= mc);
    assign scan_found  = !scan_fail && !scan_bit
                         && ((SPAN_W'(run_len_inc) == cspan_eff) || (scan_col_reg == mc - 7'd1));

    assign col_end_wide = {1'b0, col_reg} + {1'b0, cs_reg};
    assign slot_sum     = {2'b00, slot_count_reg} + {1'b0, area_reg};

    always_comb
    begin
        for (int i = 0; i < COL_DEPTH; i++)
        begin
            rect[i] = ((CNT_W+1)'(i) >= {1'b0, col_reg}) && ((CNT_W+1)'(i) < col_end_wide);
        end
    end

    always_comb
    begin
        status.in_table   = ({1'b0, item_reg.row_number} < rc);
        status.last_issue = (ptr_reg == row_end_reg - 7'd1);
        status.scan_fail  = scan_fail;
        status.scan_found = scan_found;
        status.budget_ok  = (area_reg <= AREA_W'(budget_cfg_reg))
                            && (slot_sum <= (AREA_W+1)'(budget_cfg_reg));
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg   <= ROWS_RESET;
            cols_cfg_reg   <= COLUMNS_RESET;
            budget_cfg_reg <= BUDGET_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_ROWS_IN_USE:    rows_cfg_reg   <= cfg_data[CNT_W-1:0];
                REG_COLUMNS_IN_USE: cols_cfg_reg   <= cfg_data[CNT_W-1:0];
                REG_CELL_BUDGET:    budget_cfg_reg <= cfg_data[BUDGET_W-1:0];
                default:            rows_cfg_reg   <= rows_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            slot_count_reg <= '0;
            widest_reg     <= '0;
            placed_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.rd_issue;
            if (cmd.rd_issue)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (cmd.load)
            begin
                placed_reg <= 1'b0;
                if (in_data.first_cell)
                begin
                    row_valid_reg  <= '0;
                    slot_count_reg <= '0;
                    widest_reg     <= '0;
                end
            end
            if (wr_en)
            begin
                row_valid_reg[rd_addr_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                placed_reg     <= 1'b1;
                slot_count_reg <= slot_sum[BUDGET_W-1:0];
                if (col_end_wide[CNT_W-1:0] > widest_reg)
                begin
                    widest_reg <= col_end_wide[CNT_W-1:0];
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            mem[rd_addr_reg] <= rd_data_eff | rect;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.setup)
        begin
            rs_reg        <= rs_next;
            row_end_reg   <= {1'b0, item_reg.row_number} + rs_next;
            ptr_reg       <= {1'b0, item_reg.row_number};
            mask_reg      <= '0;
            scan_col_reg  <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
        end
        if (cmd.rd_issue)
        begin
            ptr_reg <= ptr_reg + 7'd1;
        end
        if (cmd.acc && pend_reg)
        begin
            mask_reg <= mask_reg | rd_data_eff;
        end
        if (cmd.scan_step)
        begin
            scan_col_reg <= scan_col_reg + 7'd1;
            if (scan_bit)
            begin
                run_len_reg   <= '0;
                run_start_reg <= scan_col_reg + 7'd1;
            end
            else
            begin
                run_len_reg <= run_len_inc;
            end
            if (scan_found)
            begin
                col_reg <= run_start_reg;
                cs_reg  <= run_len_inc;
            end
        end
        if (cmd.area)
        begin
            area_reg <= AREA_W'(rs_reg) * AREA_W'(cs_reg);
        end
        if (cmd.commit)
        begin
            ptr_reg <= {1'b0, item_reg.row_number};
        end
        if (cmd.out_load)
        begin
            out_data_reg.placed       <= placed_reg;
            out_data_reg.echo_row     <= item_reg.row_number;
            out_data_reg.echo_cell    <= item_reg.cell_number;
            out_data_reg.row_end      <= placed_reg ? row_end_reg : '0;
            out_data_reg.column_start <= placed_reg ? col_reg[ROW_W-1:0] : '0;
            out_data_reg.column_end   <= placed_reg ? col_end_wide[CNT_W-1:0] : '0;
            out_data_reg.grid_columns <= widest_reg;
            out_data_reg.slots_used   <= slot_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/table_cell_slot_placer_unit.sv =====
// Top level of the table cell slot placer.
// Joins the controller tcsp_ctrl and the datapath tcsp_datapath; uses tcsp_pkg.
//
// Usage: cells arrive on the input channel (in_valid, in_stall, in_data) in row
// order, one transfer per cell; a cell with first_cell set starts a new table
// and clears the occupancy bitmap and the counters. Each cell gives exactly one
// result transfer on the output channel (out_valid, out_stall, out_data).
// cfg_write_enable, cfg_index and cfg_data write rows_in_use, columns_in_use and
// cell_budget; the user must do so only while the block is idle (unenforced).
//
// One cell is in flight at a time. The time from transfer to result grows with
// the clamped row span and with the number of columns scanned; a skipped cell
// finishes sooner. The time is set by the single read port of the occupancy
// memory, which is read once per covered row to gather the rows and again to
// write them back, and by the scanner that examines one column per cycle.
//
// Reset clears the controller, the counters and the per-row valid bits, so the
// bitmap reads as empty at once. A new cell is taken while a finished result
// waits in the output register; when out_stall holds, the next result waits
// in its final state until the output register is free.
module table_cell_slot_placer_unit #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [tcsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  tcsp_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output tcsp_pkg::out_item_t              out_data
);
    import tcsp_pkg::*;

    cmd_t    cmd;
    status_t status;

    tcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    tcsp_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_data          (in_data),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .out_data         (out_data),
        .cmd              (cmd),
        .status           (status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("A second cell was taken while one is in flight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("A result appeared without a result load.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (!cmd.scan_step && !cmd.out_load && !cmd.commit))
        else $error("A memory read overlapped another phase of the cell.");

endmodule
